// ===== hw/rtl/fba_pkg.sv =====
// Shared types, codes and constants of the FAT block allocator.
`default_nettype none

package fba_pkg;

  // Table geometry default
  localparam int NUM_BLOCKS_DEF = 1024;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 10;
  localparam int ENTRY_W  = 16;
  localparam int STATUS_W = 2;
  localparam int FSB_W    = 10;

  // Configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam logic CFG_FSB_WORD = 1'b0;
  localparam logic [FSB_W-1:0] SEARCH_RESET = 10'd6;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SET   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_GET   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

  // Table entry markers
  localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'h0000;
  localparam logic [ENTRY_W-1:0] ENTRY_END  = 16'hFFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;  // clear one table entry
    logic load;   // capture the input transaction
    logic exec;   // first work cycle of an item
    logic scan;   // free-entry search cycle
    logic walk;   // chain free cycle
    logic emit;   // move result into output register
  } fba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fin;       // result captured this cycle
    logic is_alloc;  // captured item is an allocate
    logic clr_last;  // last entry of the clearing pass
  } fba_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fba_dpath.sv =====
// Datapath of the FAT block allocator: table memory, pointers and result registers.
`default_nettype none

module fba_dpath #(
  parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fba_pkg::fba_cmd_t            cmd,
  output fba_pkg::fba_sts_t                 sts,
  input  wire logic [fba_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [fba_pkg::INDEX_W-1:0]  in_block_index,
  input  wire logic [fba_pkg::ENTRY_W-1:0]  in_entry_value,
  input  wire logic [fba_pkg::FSB_W-1:0]    first_search,
  output logic [fba_pkg::STATUS_W-1:0]      out_status,
  output logic [fba_pkg::ENTRY_W-1:0]       out_value
);
  import fba_pkg::*;

  localparam int AW    = $clog2(NUM_BLOCKS);
  localparam int PTR_W = $clog2(NUM_BLOCKS + 1);

  // Table memory and read path
  logic [ENTRY_W-1:0] mem [NUM_BLOCKS];
  logic [ENTRY_W-1:0] rdata_r;
  logic [ENTRY_W-1:0] wdq_r;
  logic               byp_r;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] eff;

  // Captured item
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [INDEX_W-1:0]  idx_r, idx_nxt;
  logic [ENTRY_W-1:0]  val_r, val_nxt;

  // Pointers and counters
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [PTR_W-1:0]   steps_r, steps_nxt;
  logic [ENTRY_W-1:0] cur_r, cur_nxt;
  logic [AW-1:0]      rd_addr_r, rd_addr_nxt;
  logic               rvld_r, rvld_nxt;

  // Result registers
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [ENTRY_W-1:0]  res_val_r, res_val_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;
  logic [ENTRY_W-1:0]  out_val_r, out_val_nxt;

  // Walk checks
  logic               walk_go;
  logic [ENTRY_W-1:0] chk_val;
  logic [PTR_W-1:0]   chk_steps;
  logic               chk_term;
  logic               chk_bad;
  logic               issue_ok;
  logic               idx_ok;
  logic               fin;

  // Read data, with same-cycle write forwarded
  assign eff = byp_r ? wdq_r : rdata_r;

  assign walk_go   = cmd.walk || (cmd.exec && (op_r == OP_FREE));
  assign chk_val   = cmd.walk ? eff : ENTRY_W'(idx_r);
  assign chk_steps = cmd.walk ? (steps_r + PTR_W'(1)) : '0;
  assign chk_term  = (chk_val == ENTRY_FREE) || (chk_val == ENTRY_END);
  assign chk_bad   = (32'(chk_val) >= NUM_BLOCKS) || (32'(chk_steps) >= NUM_BLOCKS);
  assign issue_ok  = 32'(ptr_r) < NUM_BLOCKS;
  assign idx_ok    = 32'(idx_r) < NUM_BLOCKS;

  // Operation sequencing
  always_comb begin
    we          = 1'b0;
    waddr       = ptr_r[AW-1:0];
    wdata       = ENTRY_FREE;
    raddr       = AW'(in_block_index);
    fin         = 1'b0;
    op_nxt      = op_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    ptr_nxt     = ptr_r;
    steps_nxt   = steps_r;
    cur_nxt     = cur_r;
    rd_addr_nxt = rd_addr_r;
    rvld_nxt    = 1'b0;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    out_st_nxt  = out_st_r;
    out_val_nxt = out_val_r;

    if (cmd.load) begin
      op_nxt  = in_opcode;
      idx_nxt = in_block_index;
      val_nxt = in_entry_value;
    end

    // Clearing pass after reset
    if (cmd.clear) begin
      we      = 1'b1;
      waddr   = ptr_r[AW-1:0];
      wdata   = ENTRY_FREE;
      ptr_nxt = ptr_r + PTR_W'(1);
    end

    // First cycle of set, get and allocate
    if (cmd.exec) begin
      case (op_r)
        OP_SET: begin
          fin         = 1'b1;
          res_val_nxt = '0;
          if (idx_ok) begin
            we         = 1'b1;
            waddr      = AW'(idx_r);
            wdata      = val_r;
            res_st_nxt = ST_OK;
          end else begin
            res_st_nxt = ST_RANGE;
          end
        end
        OP_GET: begin
          fin = 1'b1;
          if (idx_ok) begin
            res_st_nxt  = ST_OK;
            res_val_nxt = eff;
          end else begin
            res_st_nxt  = ST_RANGE;
            res_val_nxt = '0;
          end
        end
        OP_ALLOC: begin
          if (32'(first_search) >= NUM_BLOCKS) begin
            fin         = 1'b1;
            res_st_nxt  = ST_NOFREE;
            res_val_nxt = '0;
          end else begin
            ptr_nxt = PTR_W'(first_search);
          end
        end
        default: begin
        end
      endcase
    end

    // Free-entry search: one read issued per cycle, compared in the cycle after
    if (cmd.scan) begin
      raddr       = ptr_r[AW-1:0];
      rd_addr_nxt = ptr_r[AW-1:0];
      rvld_nxt    = issue_ok;
      if (issue_ok) begin
        ptr_nxt = ptr_r + PTR_W'(1);
      end
      if (rvld_r && (eff == ENTRY_FREE)) begin
        we          = 1'b1;
        waddr       = rd_addr_r;
        wdata       = ENTRY_END;
        fin         = 1'b1;
        rvld_nxt    = 1'b0;
        res_st_nxt  = ST_OK;
        res_val_nxt = ENTRY_W'(rd_addr_r);
      end else if (!rvld_r && !issue_ok) begin
        fin         = 1'b1;
        res_st_nxt  = ST_NOFREE;
        res_val_nxt = '0;
      end
    end

    // Chain free: release current entry, follow its link
    if (cmd.walk) begin
      we    = 1'b1;
      waddr = cur_r[AW-1:0];
      wdata = ENTRY_FREE;
    end
    if (walk_go) begin
      cur_nxt   = chk_val;
      steps_nxt = chk_steps;
      if (chk_term) begin
        fin         = 1'b1;
        res_st_nxt  = ST_OK;
        res_val_nxt = '0;
      end else if (chk_bad) begin
        fin         = 1'b1;
        res_st_nxt  = ST_RANGE;
        res_val_nxt = '0;
      end else begin
        raddr = chk_val[AW-1:0];
      end
    end

    // Output register load
    if (cmd.emit) begin
      out_st_nxt  = res_st_r;
      out_val_nxt = res_val_r;
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
    wdq_r   <= wdata;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      steps_r <= '0;
      rvld_r  <= 1'b0;
      byp_r   <= 1'b0;
    end else begin
      ptr_r   <= ptr_nxt;
      steps_r <= steps_nxt;
      rvld_r  <= rvld_nxt;
      byp_r   <= we && (waddr == raddr);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    cur_r     <= cur_nxt;
    rd_addr_r <= rd_addr_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    out_st_r  <= out_st_nxt;
    out_val_r <= out_val_nxt;
  end

  assign sts.fin      = fin;
  assign sts.is_alloc = (op_r == OP_ALLOC);
  assign sts.clr_last = (ptr_r == PTR_W'(NUM_BLOCKS - 1));

  assign out_status = out_st_r;
  assign out_value  = out_val_r;

  // Walk never frees more entries than the table holds
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(steps_r) <= NUM_BLOCKS)
    else $error("walk step count past table size");

  // A search read in flight is always the one just behind the issue pointer
  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    rvld_r |-> (32'(rd_addr_r) + 32'd1 == 32'(ptr_r)))
    else $error("search pipeline out of step with pointer");

  // Chain free only writes inside the table
  a_walk_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> (32'(cur_r) < NUM_BLOCKS))
    else $error("chain free write outside table");

endmodule

`default_nettype wire

// ===== hw/rtl/fba_ctrl.sv =====
// Controller state machine of the FAT block allocator.
`default_nettype none

module fba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output fba_pkg::fba_cmd_t      cmd,
  input  wire fba_pkg::fba_sts_t sts
);
  import fba_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       emit;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign emit       = (state_r == ST_FIN) && (!out_vld_r || out_tready);

  // Commands
  always_comb begin
    cmd       = '0;
    cmd.clear = (state_r == ST_CLEAR);
    cmd.load  = in_tvalid && in_tready;
    cmd.exec  = (state_r == ST_EXEC);
    cmd.scan  = (state_r == ST_SCAN);
    cmd.walk  = (state_r == ST_WALK);
    cmd.emit  = emit;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (sts.fin) begin
          state_nxt = ST_FIN;
        end else if (sts.is_alloc) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_SCAN, ST_WALK: if (sts.fin) state_nxt = ST_FIN;
      ST_FIN:  if (emit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Datapath reports a result only while an item is at work
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.fin |-> (state_r == ST_EXEC || state_r == ST_SCAN || state_r == ST_WALK))
    else $error("result reported outside work states");

  // A waiting result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !emit)
    else $error("output register overwritten while stalled");

  // An accepted transaction starts work on the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_EXEC))
    else $error("accepted transaction did not start");

endmodule

`default_nettype wire

// ===== hw/rtl/fat_block_allocator.sv =====
// Top level of the FAT block allocator: ports, configuration register, controller and datapath.
//
// Channel  Direction  Transaction content
// in_*     input      opcode, block_index, entry_value
// out_*    output     status, result_value
// cfg_*    input      first_search_block at byte address 0
//
// After reset a clearing pass writes every entry free, with in_tready low.
// Set and get finish in the work state; a free chain frees its entries one by one along the
// links. Allocate reads entries in turn from first_search_block up to the end of the table
// and takes the first free one, or reports no free block when none turns up, bound by the
// single table read port. One item is worked at a time; a result waiting on out_tready does
// not stop the next item from being accepted and worked.
`default_nettype none

module fat_block_allocator #(
  parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // [1:0] opcode, [11:2] block_index, [27:12] entry_value, [31:28] zero
  input  wire logic [31:0]                    in_tdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [1:0] status, [17:2] result_value, [23:18] zero
  output logic [23:0]                         out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [fba_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [fba_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [fba_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import fba_pkg::*;

  logic [FSB_W-1:0]    fsb_r, fsb_nxt;
  logic                cfg_wr;
  fba_cmd_t            cmd;
  fba_sts_t            sts;
  logic [STATUS_W-1:0] res_status;
  logic [ENTRY_W-1:0]  res_value;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == CFG_FSB_WORD);
  assign fsb_nxt    = cfg_wr ? cfg_pwdata[FSB_W-1:0] : fsb_r;
  assign cfg_prdata = (cfg_paddr[2] == CFG_FSB_WORD) ? CFG_DATA_W'(fsb_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsb_r <= SEARCH_RESET;
    end else begin
      fsb_r <= fsb_nxt;
    end
  end

  fba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  fba_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_tdata[1:0]),
    .in_block_index (in_tdata[11:2]),
    .in_entry_value (in_tdata[27:12]),
    .first_search   (fsb_r),
    .out_status     (res_status),
    .out_value      (res_value)
  );

  assign out_tdata = {6'b0, res_value, res_status};

endmodule

`default_nettype wire
